// ===== rtl/bwdp_pkg.sv =====
// ----------------------------------------------------------------------------
// bwdp_pkg
// Shared types and constants of the binary weight dot product block.
// ----------------------------------------------------------------------------
package bwdp_pkg;

  // lanes per beat and element widths
  localparam int LANES      = 8;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int ACT_W      = 16;
  localparam int LSUM_W     = ACT_W + LANE_IDX_W;
  localparam int SUM_W      = 32;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  localparam int PROD_W     = SUM_W + SCALE_W + 1;

  // row geometry
  localparam int VLEN_W        = 16;
  localparam int MAX_ROW_BYTES = 8192;
  localparam int BPOS_W        = $clog2(MAX_ROW_BYTES);
  localparam int ROWB_W        = BPOS_W + 1;

  localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(64);

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic REG_VECTOR_LENGTH = 1'b0;

  // result queue depth
  localparam int OUTQ_DEPTH = 8;

  // control that travels with a beat down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

// ===== rtl/bwdp_lane.sv =====
// ----------------------------------------------------------------------------
// bwdp_lane
// One lane: masks its activation by weight bit and row length, registered.
// ----------------------------------------------------------------------------
module bwdp_lane import bwdp_pkg::*; (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    weight_bit,
  input  logic signed [ACT_W-1:0] act,
  input  logic [VLEN_W-1:0]       elem_idx,
  input  logic [VLEN_W-1:0]       vector_length,
  output logic signed [ACT_W-1:0] lane_act
);

  logic lane_on;

  // element counts only when its weight is set and it lies inside the row
  assign lane_on = weight_bit && (elem_idx < vector_length);

  always_ff @(posedge clk) begin
    if (load) begin
      lane_act <= lane_on ? act : '0;
    end
  end

endmodule

// ===== rtl/bwdp_merge.sv =====
// ----------------------------------------------------------------------------
// bwdp_merge
// Adds the lane values of a beat and accumulates the row sum; emits the
// final row sum and scale on the last beat of a row.
// ----------------------------------------------------------------------------
module bwdp_merge import bwdp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctl_t               in_ctl,
  input  logic signed [ACT_W-1:0] lane_act [LANES],
  input  logic [SCALE_W-1:0]      in_scale,
  output pipe_ctl_t               out_ctl,
  output logic signed [SUM_W-1:0] out_total,
  output logic [SCALE_W-1:0]      out_scale
);

  localparam logic signed [SUM_W:0] SUM_MAX = $signed({2'b00, {(SUM_W-1){1'b1}}});
  localparam logic signed [SUM_W:0] SUM_MIN = $signed({2'b11, {(SUM_W-1){1'b0}}});

  logic signed [ACT_W:0]    pair_sum [LANES/2];
  logic signed [ACT_W+1:0]  quad_sum [LANES/4];
  logic signed [LSUM_W-1:0] beat_sum;

  pipe_ctl_t                s2_ctl;
  logic signed [LSUM_W-1:0] s2_sum;
  logic [SCALE_W-1:0]       s2_scale;

  logic signed [SUM_W-1:0]  row_sum;
  logic signed [SUM_W:0]    acc_wide;
  logic signed [SUM_W-1:0]  acc_sat;

  // adder tree over the lanes
  always_comb begin
    for (int i = 0; i < LANES/2; i++) begin
      pair_sum[i] = (ACT_W+1)'(lane_act[2*i]) + (ACT_W+1)'(lane_act[2*i+1]);
    end
    for (int i = 0; i < LANES/4; i++) begin
      quad_sum[i] = (ACT_W+2)'(pair_sum[2*i]) + (ACT_W+2)'(pair_sum[2*i+1]);
    end
    beat_sum = LSUM_W'(quad_sum[0]) + LSUM_W'(quad_sum[1]);
  end

  // tree stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= in_ctl;
    end
    s2_sum   <= beat_sum;
    s2_scale <= in_scale;
  end

  // saturating accumulate
  always_comb begin
    acc_wide = (SUM_W+1)'(row_sum) + (SUM_W+1)'(s2_sum);
    if (acc_wide > SUM_MAX) begin
      acc_sat = SUM_MAX[SUM_W-1:0];
    end else if (acc_wide < SUM_MIN) begin
      acc_sat = SUM_MIN[SUM_W-1:0];
    end else begin
      acc_sat = acc_wide[SUM_W-1:0];
    end
  end

  // row accumulator, cleared after the last beat of a row
  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum <= '0;
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= s2_ctl.valid && s2_ctl.last;
      out_ctl.last  <= s2_ctl.last;
      if (s2_ctl.valid) begin
        row_sum <= s2_ctl.last ? '0 : acc_sat;
      end
    end
    out_total <= acc_sat;
    out_scale <= s2_scale;
  end

endmodule

// ===== rtl/bwdp_scale.sv =====
// ----------------------------------------------------------------------------
// bwdp_scale
// Multiplies the row sum by the row scale, rounds to Q.8 and saturates.
// ----------------------------------------------------------------------------
module bwdp_scale import bwdp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctl_t               in_ctl,
  input  logic signed [SUM_W-1:0] in_total,
  input  logic [SCALE_W-1:0]      in_scale,
  output logic                    res_valid,
  output logic signed [SUM_W-1:0] res_value
);

  localparam int SHR_W = PROD_W - SCALE_FRAC;
  localparam logic signed [SHR_W-1:0] RES_MAX =
    $signed({{(SHR_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}});
  localparam logic signed [SHR_W-1:0] RES_MIN =
    $signed({{(SHR_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}});
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2**(SCALE_FRAC-1));

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [SHR_W-1:0]  shifted;
  logic signed [SUM_W-1:0]  res_sat;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_ctl.valid;
    end
    prod <= PROD_W'(in_total * $signed({1'b0, in_scale}));
  end

  // round half up, floor shift, clamp
  always_comb begin
    prod_rnd = prod + ROUND_HALF;
    shifted  = SHR_W'(prod_rnd >>> SCALE_FRAC);
    if (shifted > RES_MAX) begin
      res_sat = RES_MAX[SUM_W-1:0];
    end else if (shifted < RES_MIN) begin
      res_sat = RES_MIN[SUM_W-1:0];
    end else begin
      res_sat = shifted[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= prod_valid;
    end
    res_value <= res_sat;
  end

endmodule

// ===== rtl/bwdp_outq.sv =====
// ----------------------------------------------------------------------------
// bwdp_outq
// Result queue; holds finished dot values until the consumer takes them.
// ----------------------------------------------------------------------------
module bwdp_outq import bwdp_pkg::*; #(
  parameter int DEPTH = OUTQ_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic signed [SUM_W-1:0] push_value,
  output logic                    dot_valid,
  input  logic                    dot_stall,
  output logic signed [SUM_W-1:0] dot_value
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic signed [SUM_W-1:0] entry [DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    pop;

  assign pop       = dot_valid && !dot_stall;
  assign dot_valid = (count != '0);
  assign dot_value = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_value;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/binary_weight_dot_product.sv =====
// ----------------------------------------------------------------------------
// binary_weight_dot_product
// Streaming dot product of packed binary weights with Q8.8 activations,
// scaled per row and saturated to a signed Q.8 result.
// ----------------------------------------------------------------------------
// One beat per clock is taken while item_stall is low: eight lanes mask and
// select their activations in parallel, an adder tree merges them and one
// accumulator keeps the row sum. A row result then goes through the scale
// stage and the output queue to dot_valid. Up to QUEUE_DEPTH results may be
// outstanding (in the pipeline or waiting in the output queue); item_stall
// rises only when that many have not yet been taken. vector_length sets the
// row length in elements; a value of zero makes every beat a one-byte row
// with result 0, and a new length applies from the next beat on.
// ----------------------------------------------------------------------------
module binary_weight_dot_product import bwdp_pkg::*; #(
  parameter int QUEUE_DEPTH = OUTQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready,
  // input beats
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [LANES-1:0]             weight_bits,
  input  logic signed [ACT_W-1:0]      act_lane0,
  input  logic signed [ACT_W-1:0]      act_lane1,
  input  logic signed [ACT_W-1:0]      act_lane2,
  input  logic signed [ACT_W-1:0]      act_lane3,
  input  logic signed [ACT_W-1:0]      act_lane4,
  input  logic signed [ACT_W-1:0]      act_lane5,
  input  logic signed [ACT_W-1:0]      act_lane6,
  input  logic signed [ACT_W-1:0]      act_lane7,
  input  logic [SCALE_W-1:0]           row_scale,
  // results
  output logic                         dot_valid,
  input  logic                         dot_stall,
  output logic signed [SUM_W-1:0]      dot_value
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [VLEN_W-1:0]       vector_length;
  logic                    cfg_wr;

  logic                    accept;
  logic [BPOS_W-1:0]       byte_position;
  logic [VLEN_W:0]         vlen_plus;
  logic [ROWB_W-1:0]       row_bytes;
  logic                    row_end;
  logic [VLEN_W-1:0]       base_idx;

  logic signed [ACT_W-1:0] act_in   [LANES];
  logic signed [ACT_W-1:0] lane_act [LANES];

  pipe_ctl_t               s1_ctl;
  logic [SCALE_W-1:0]      s1_scale;
  pipe_ctl_t               row_ctl;
  logic signed [SUM_W-1:0] row_total;
  logic [SCALE_W-1:0]      row_scl;
  logic                    res_valid;
  logic signed [SUM_W-1:0] res_value;

  logic [OCC_W-1:0]        occ;
  logic                    reserve;
  logic                    pop;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_RESET;
    end else if (cfg_wr && (paddr[CFG_ADDR_W-1] == REG_VECTOR_LENGTH)) begin
      vector_length <= pwdata[VLEN_W-1:0];
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1] == REG_VECTOR_LENGTH) begin
      prdata = CFG_DATA_W'(vector_length);
    end else begin
      prdata = '0;
    end
  end

  // input handshake, stalled only while all result slots are taken
  assign accept     = item_valid && !item_stall;
  assign item_stall = (occ == OCC_W'(QUEUE_DEPTH));

  // row geometry: bytes per row, at least one
  always_comb begin
    vlen_plus = {1'b0, vector_length} + (VLEN_W+1)'(LANES - 1);
    row_bytes = vlen_plus[VLEN_W:LANE_IDX_W];
    if (row_bytes == '0) begin
      row_bytes = ROWB_W'(1);
    end
  end

  assign row_end  = (ROWB_W'(byte_position) + ROWB_W'(1)) >= row_bytes;
  assign base_idx = {byte_position, LANE_IDX_W'(0)};

  // byte position within the row
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= row_end ? '0 : byte_position + 1'b1;
    end
  end

  // lane activations
  assign act_in[0] = act_lane0;
  assign act_in[1] = act_lane1;
  assign act_in[2] = act_lane2;
  assign act_in[3] = act_lane3;
  assign act_in[4] = act_lane4;
  assign act_in[5] = act_lane5;
  assign act_in[6] = act_lane6;
  assign act_in[7] = act_lane7;

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    bwdp_lane u_lane (
      .clk           (clk),
      .load          (accept),
      .weight_bit    (weight_bits[n]),
      .act           (act_in[n]),
      .elem_idx      (base_idx + VLEN_W'(n)),
      .vector_length (vector_length),
      .lane_act      (lane_act[n])
    );
  end

  // control and scale beside the lane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= accept;
      s1_ctl.last  <= row_end;
    end
    if (accept) begin
      s1_scale <= row_scale;
    end
  end

  bwdp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (s1_ctl),
    .lane_act  (lane_act),
    .in_scale  (s1_scale),
    .out_ctl   (row_ctl),
    .out_total (row_total),
    .out_scale (row_scl)
  );

  bwdp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (row_ctl),
    .in_total  (row_total),
    .in_scale  (row_scl),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  bwdp_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_value (res_value),
    .dot_valid  (dot_valid),
    .dot_stall  (dot_stall),
    .dot_value  (dot_value)
  );

  // outstanding results: reserved at the row's last beat, freed when taken
  assign reserve = accept && row_end;
  assign pop     = dot_valid && !dot_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(reserve) - OCC_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("result slot count above queue depth");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> byte_position == '0)
    else $error("byte position not cleared after row end");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !row_end |=> byte_position == BPOS_W'($past(byte_position) + 1'b1))
    else $error("byte position did not advance");

  a_result_credit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> occ != '0)
    else $error("result produced without a reserved slot");
`endif

endmodule

// ===== dv/binary_weight_dot_product_tb.sv =====
// ----------------------------------------------------------------------------
// binary_weight_dot_product_tb
// Self-checking bench for the binary weight dot product block.
// ----------------------------------------------------------------------------
// Beats go in through the valid/stall input port and row results are taken
// from the valid/stall output port. Both sides idle at random. Every
// accepted beat runs through a bit-exact row model in the bench, and each
// row result is compared with the oldest pending value. The run starts with
// a short directed list (reset length, field extremes, rounding, masking,
// zero length, a length change in mid-row). It then runs long saturating
// rows, a row at the largest length cut short by a smaller length, and
// random phases, each with its own length.
// ----------------------------------------------------------------------------
module binary_weight_dot_product_tb;
  import bwdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // give the pipeline some margin to drain before a register write
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_BEATS  = 500;
  localparam int SAT_LENGTH    = 4200;
  localparam int LONG_BEATS    = 40;
  localparam logic [CFG_ADDR_W-1:0] VLEN_ADDR = CFG_ADDR_W'(4 * int'(REG_VECTOR_LENGTH));

  typedef struct {
    logic [LANES-1:0]          wb;
    logic signed [ACT_W-1:0]   act [LANES];
    logic [SCALE_W-1:0]        sc;
  } beat_t;

  // directed row: optional length write, beat content, optional fixed result
  typedef struct {
    int                      vlen;
    logic [LANES-1:0]        wb;
    logic signed [ACT_W-1:0] a0;
    logic signed [ACT_W-1:0] arest;
    logic [SCALE_W-1:0]      sc;
    bit                      typed;
    logic signed [SUM_W-1:0] want;
  } dir_row_t;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    item_valid;
  logic                    item_stall;
  logic [LANES-1:0]        weight_bits;
  logic signed [ACT_W-1:0] act_lane0;
  logic signed [ACT_W-1:0] act_lane1;
  logic signed [ACT_W-1:0] act_lane2;
  logic signed [ACT_W-1:0] act_lane3;
  logic signed [ACT_W-1:0] act_lane4;
  logic signed [ACT_W-1:0] act_lane5;
  logic signed [ACT_W-1:0] act_lane6;
  logic signed [ACT_W-1:0] act_lane7;
  logic [SCALE_W-1:0]      row_scale;
  logic                    dot_valid;
  logic                    dot_stall;
  logic signed [SUM_W-1:0] dot_value;

  // row model state and pending row results
  logic [VLEN_W-1:0]       vlen_cfg = VLEN_RESET;
  logic signed [SUM_W-1:0] run_sum  = '0;
  logic [BPOS_W-1:0]       byte_pos = '0;
  logic signed [SUM_W-1:0] dot_q [$];

  int errors       = 0;
  int rows_checked = 0;
  int beats_sent   = 0;
  int cfg_writes   = 0;
  int src_gap_max  = 11;
  int snk_gap_max  = 11;

  dir_row_t dir_tab [24];

  binary_weight_dot_product u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .weight_bits (weight_bits),
    .act_lane0   (act_lane0),
    .act_lane1   (act_lane1),
    .act_lane2   (act_lane2),
    .act_lane3   (act_lane3),
    .act_lane4   (act_lane4),
    .act_lane5   (act_lane5),
    .act_lane6   (act_lane6),
    .act_lane7   (act_lane7),
    .row_scale   (row_scale),
    .dot_valid   (dot_valid),
    .dot_stall   (dot_stall),
    .dot_value   (dot_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL binary_weight_dot_product");
    $finish;
  end

  function automatic longint sat32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // one beat into the row: masked accumulate, scaled result on the last byte
  function automatic bit advance_row(input beat_t b, output logic signed [SUM_W-1:0] res);
    int     row_bytes;
    int     base;
    int     n;
    longint acc;
    longint prod;
    longint scaled;
    row_bytes = (int'(vlen_cfg) + 7) / 8;
    if (row_bytes == 0) row_bytes = 1;
    if (row_bytes > MAX_ROW_BYTES) row_bytes = MAX_ROW_BYTES;
    base = int'(byte_pos) * 8;
    acc  = longint'(run_sum);
    res  = '0;
    for (n = 0; n < LANES; n++) begin
      if (b.wb[n] && (base + n) < int'(vlen_cfg)) acc = sat32(acc + longint'(b.act[n]));
    end
    // not the last byte yet: keep the partial sum
    if (int'(byte_pos) + 1 < row_bytes) begin
      run_sum  = acc[SUM_W-1:0];
      byte_pos = byte_pos + 1'b1;
      return 1'b0;
    end
    // Q.20 product, round half up, back to Q.8
    prod   = acc * longint'(b.sc) + (64'sd1 <<< (SCALE_FRAC - 1));
    scaled = sat32(prod >>> SCALE_FRAC);
    res    = scaled[SUM_W-1:0];
    run_sum  = '0;
    byte_pos = '0;
    return 1'b1;
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 11;
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int    n;
    case ($urandom_range(0, 5))
      0: b.wb = 8'h00;
      1: b.wb = 8'hFF;
      default: b.wb = LANES'($urandom);
    endcase
    for (n = 0; n < LANES; n++) begin
      case ($urandom_range(0, 9))
        0: b.act[n] = 16'h7FFF;
        1: b.act[n] = 16'h8000;
        2: b.act[n] = ACT_W'($urandom_range(0, 15));
        default: b.act[n] = ACT_W'($urandom);
      endcase
    end
    case ($urandom_range(0, 7))
      0: b.sc = '0;
      1: b.sc = 16'hFFFF;
      2: b.sc = 16'd4096;
      default: b.sc = SCALE_W'($urandom);
    endcase
    return b;
  endfunction

  function automatic logic [VLEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'd1;
      2: return VLEN_W'($urandom_range(2, 8));
      7: return VLEN_W'($urandom_range(65, 200));
      8: return VLEN_W'(8 * $urandom_range(1, 8));
      9: return VLEN_W'($urandom_range(201, 1000));
      default: return VLEN_W'($urandom_range(9, 64));
    endcase
  endfunction

  // drive one beat, model it once accepted; called and returns at falling edge
  task automatic send_beat(input beat_t b, input bit typed, input logic signed [SUM_W-1:0] want);
    int                      gap;
    bit                      has;
    logic signed [SUM_W-1:0] res;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid  <= 1'b1;
    weight_bits <= b.wb;
    act_lane0   <= b.act[0];
    act_lane1   <= b.act[1];
    act_lane2   <= b.act[2];
    act_lane3   <= b.act[3];
    act_lane4   <= b.act[4];
    act_lane5   <= b.act[5];
    act_lane6   <= b.act[6];
    act_lane7   <= b.act[7];
    row_scale   <= b.sc;
    do @(posedge clk); while (item_stall);
    has = advance_row(b, res);
    if (has) dot_q.push_back(typed ? want : res);
    beats_sent++;
    @(negedge clk);
  endtask

  // wait for every row result, then let the pipeline empty
  task automatic settle();
    item_valid <= 1'b0;
    while (dot_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write: setup then access phase, then read back
  task automatic write_vlen(input logic [VLEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VLEN_ADDR;
    pwdata  <= CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    vlen_cfg = v;
    cfg_writes++;
    @(negedge clk);
    if (prdata !== CFG_DATA_W'(v)) begin
      $error("vector_length: expected %0d, actual %0d", v, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: random stall before each result is taken
  initial begin : result_sink
    int w;
    dot_stall = 1'b0;
    @(negedge clk);
    forever begin
      w = $urandom_range(0, snk_gap_max);
      if (w > 0) begin
        dot_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      dot_stall <= 1'b0;
      do @(posedge clk); while (!(dot_valid && !dot_stall));
      @(negedge clk);
    end
  end

  // result check against the oldest pending row
  always @(posedge clk) begin
    if (!rst && dot_valid && !dot_stall) begin
      if (dot_q.size() == 0) begin
        $error("dot_value: no result pending, actual %0d", dot_value);
        errors++;
      end else begin
        logic signed [SUM_W-1:0] want;
        want = dot_q.pop_front();
        rows_checked++;
        if (dot_value !== want) begin
          $error("dot_value: expected %0d, actual %0d", want, dot_value);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    beat_t             b;
    int                i;
    int                k;
    int                n;
    int                rb;
    int                n_items;
    int                rand_beats;
    logic [VLEN_W-1:0] vl;

    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    item_valid  = 1'b0;
    weight_bits = '0;
    act_lane0   = '0;
    act_lane1   = '0;
    act_lane2   = '0;
    act_lane3   = '0;
    act_lane4   = '0;
    act_lane5   = '0;
    act_lane6   = '0;
    act_lane7   = '0;
    row_scale   = '0;
    rand_beats  = 0;

    // length, weights, lane 0, other lanes, scale, fixed result
    dir_tab = '{
      // reset length of 64: one full eight-byte row, scale only counts at the end
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'd4096, 1'b1, 32'sd2097088},
      // one-byte rows: activation and scale extremes
      '{8,  8'hFF, 16'h7FFF, 16'h7FFF, 16'd4096, 1'b1, 32'sd262136},
      '{-1, 8'hFF, 16'h8000, 16'h8000, 16'd4096, 1'b1, -32'sd262144},
      '{-1, 8'h00, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 32'sd0},
      '{-1, 8'hFF, 16'h7FFF, 16'h7FFF, 16'd0,    1'b1, 32'sd0},
      '{-1, 8'h55, 16'sd1234, -16'sd777, 16'h9ABC, 1'b0, 32'sd0},
      // rounding half up
      '{-1, 8'h01, 16'sd1,  16'sd0, 16'd2048, 1'b1, 32'sd1},
      '{-1, 8'h01, -16'sd1, 16'sd0, 16'd2048, 1'b1, 32'sd0},
      '{-1, 8'h01, -16'sd1, 16'sd0, 16'd2049, 1'b1, -32'sd1},
      // lanes past the row are masked
      '{3,  8'hFF, 16'sd100, 16'sd100, 16'd4096, 1'b1, 32'sd300},
      // zero length: every beat is a one-byte row with result 0
      '{0,  8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 32'sd0},
      // single element rows
      '{1,  8'hFE, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1, 32'sd0},
      '{-1, 8'h01, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0},
      // two-byte row
      '{16, 8'hFF, 16'sd1000, 16'sd1000, 16'd0,    1'b0, 32'sd0},
      '{-1, 8'hFF, 16'sd1000, 16'sd1000, 16'd4096, 1'b1, 32'sd16000},
      // length cut mid-row: the next beat closes the row, all its lanes masked
      '{24, 8'hFF, 16'sd500, 16'sd500, 16'd0,    1'b0, 32'sd0},
      '{8,  8'hFF, 16'sd500, 16'sd500, 16'd4096, 1'b1, 32'sd4000}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed list
    for (i = 0; i < $size(dir_tab); i++) begin
      if (dir_tab[i].vlen >= 0) begin
        settle();
        write_vlen(VLEN_W'(dir_tab[i].vlen));
      end
      b.wb = dir_tab[i].wb;
      b.act[0] = dir_tab[i].a0;
      for (n = 1; n < LANES; n++) b.act[n] = dir_tab[i].arest;
      b.sc = dir_tab[i].sc;
      send_beat(b, dir_tab[i].typed, dir_tab[i].want);
    end

    // long rows of full weights that saturate the result both ways
    settle();
    write_vlen(VLEN_W'(SAT_LENGTH));
    for (k = 0; k < 2; k++) begin
      b.wb = 8'hFF;
      for (n = 0; n < LANES; n++) b.act[n] = (k == 0) ? 16'h7FFF : 16'h8000;
      b.sc = 16'hFFFF;
      for (i = 0; i < (SAT_LENGTH + 7) / 8; i++) send_beat(b, 1'b0, '0);
    end

    // a row at the largest length, closed early by a one-byte length
    settle();
    write_vlen(16'hFFFF);
    for (i = 0; i < LONG_BEATS; i++) send_beat(rand_beat(), 1'b0, '0);
    settle();
    write_vlen(16'd8);
    send_beat(rand_beat(), 1'b0, '0);

    // random phases, each with its own length and idle pattern
    while (rand_beats < RANDOM_BEATS) begin
      settle();
      vl = pick_length();
      write_vlen(vl);
      src_gap_max = pick_gap_max();
      snk_gap_max = pick_gap_max();
      rb = (int'(vl) + 7) / 8;
      if (rb == 0) rb = 1;
      n_items = $urandom_range(30, 90);
      // mostly whole rows, sometimes a phase that stops mid-row
      if ($urandom_range(0, 3) != 0) n_items = ((n_items + rb - 1) / rb) * rb;
      for (i = 0; i < n_items; i++) send_beat(rand_beat(), 1'b0, '0);
      rand_beats += n_items;
    end

    settle();
    $display("%0d beats driven, %0d row results checked", beats_sent, rows_checked);
    $display("%0d length writes, from zero up to the full 65535", cfg_writes);
    if (errors == 0) begin
      $display("PASS binary_weight_dot_product");
    end else begin
      $display("FAIL binary_weight_dot_product");
    end
    $finish;
  end

endmodule
